// ===== hdl/gsdr_pkg.sv =====
package gsdr_pkg;

	localparam int WINDOW_LEN_DEF = 15;

	localparam logic [23:0] VEL_GAIN_RST  = 24'd166090;
	localparam logic [23:0] DIST_GAIN_RST = 24'd324405;
	localparam logic [15:0] REC_TICKS_RST = 16'd20;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_BUTTON = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_REC  = 2'd1,
		MODE_FIN  = 2'd2,
		MODE_BAD  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_VEL_GAIN  = 2'd0,
		REG_DIST_GAIN = 2'd1,
		REG_REC_TICKS = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_SUMS, ST_SQ, ST_ROOT, ST_SCALE, ST_OUT
	} bst_t;

	// One classified item travelling from the front to the back.
	typedef struct packed {
		logic        is_sample;
		logic        is_button;
		logic        is_tick;
		logic [15:0] rate_x;
		logic [15:0] rate_y;
		logic [15:0] rate_z;
	} job_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic        sample_used;
		logic [23:0] velocity;
		logic [31:0] distance;
	} result_t;

endpackage

// ===== hdl/gsdr_front.sv =====
module gsdr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [55:0]          s_tdata,
	output logic                 q_valid,
	input  logic                 q_ready,
	output gsdr_pkg::job_t       q_job
);
	import gsdr_pkg::*;

	// Two-entry queue of classified items.
	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	job_t       job;
	cmd_t       cmd;
	logic       push, pop;

	assign cmd = cmd_t'(s_tdata[1:0]);

	always_comb begin
		job = '0;
		job.rate_x = s_tdata[17:2];
		job.rate_y = s_tdata[33:18];
		job.rate_z = s_tdata[49:34];
		unique case (cmd)
			CMD_SAMPLE: job.is_sample = 1'b1;
			CMD_BUTTON: job.is_button = 1'b1;
			CMD_TICK:   job.is_tick = 1'b1;
			default: ;
		endcase
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== hdl/gsdr_back.sv =====
module gsdr_back #(
	parameter int WINDOW_LEN = gsdr_pkg::WINDOW_LEN_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  gsdr_pkg::job_t       q_job,
	input  logic [23:0]          vel_gain,
	input  logic [23:0]          dist_gain,
	input  logic [15:0]          rec_ticks,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output gsdr_pkg::result_t    m_res
);
	import gsdr_pkg::*;

	localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int SUM_W  = 16 + $clog2(WINDOW_LEN + 1);
	localparam int DIF_W  = SUM_W + 1;
	localparam int SQ_W   = 2 * DIF_W + 2;
	localparam int RT_W   = SQ_W / 2 + 1;
	localparam int ITERS  = SQ_W / 2;

	bst_t state_q, state_d;
	mode_t mode_q;
	logic [15:0] tick_q;
	logic [SLOT_W-1:0] slot_q;
	logic signed [SUM_W-1:0] sum_q [3];
	logic signed [SUM_W-1:0] prev_q [3];
	logic [31:0] dist_q;
	logic [23:0] vel_q;
	logic [WINDOW_LEN-1:0] valid_q;
	job_t job_q;
	logic [47:0] old_rd;
	logic [47:0] old_s1;
	logic used_q;
	logic [1:0] axis_q;
	logic [SQ_W-1:0] sqs_q, sqd_q;
	logic [SQ_W-1:0] rem_q [2];
	logic [SQ_W-1:0] root_q [2];
	logic [SQ_W-1:0] bit_q;
	logic [$clog2(ITERS+1)-1:0] it_q;
	logic [47:0] pv_q, pd_q;
	logic load, do_sample;

	// Window lives in a RAM; unwritten slots read as zero through per-slot valid bits.
	logic valid_r_q;
	gsdr_ram #(.WIDTH(48), .DEPTH(WINDOW_LEN)) u_win (
		.clk(clk), .we(state_q == ST_SUMS), .waddr(slot_q),
		.wdata({job_q.rate_z, job_q.rate_y, job_q.rate_x}),
		.raddr(slot_q), .rdata(old_rd)
	);
	assign old_s1 = valid_r_q ? old_rd : 48'd0;

	assign q_ready = (state_q == ST_IDLE);
	assign load = q_valid && q_ready;
	assign do_sample = job_q.is_sample && (mode_q == MODE_REC);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_res = '{mode: mode_q, sample_used: used_q, velocity: vel_q, distance: dist_q};

	function automatic logic [SQ_W-1:0] sq(input logic signed [DIF_W-1:0] d);
		logic [DIF_W-1:0] m;
		m = d[DIF_W-1] ? DIF_W'(-d) : DIF_W'(d);
		return SQ_W'(m) * SQ_W'(m);
	endfunction

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (load) state_d = q_job.is_sample ? ST_READ : ST_OUT;
			ST_READ:  state_d = do_sample ? ST_SUMS : ST_OUT;
			ST_SUMS:  state_d = ST_SQ;
			ST_SQ:    if (axis_q == 2'd2) state_d = ST_ROOT;
			ST_ROOT:  if (it_q == ($clog2(ITERS+1))'(ITERS - 1)) state_d = ST_SCALE;
			ST_SCALE: state_d = ST_OUT;
			ST_OUT:   if (m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	logic [SQ_W-1:0] t0, t1;
	logic [55:0] vsh, dsum;
	always_comb begin
		t0 = root_q[0] + bit_q;
		t1 = root_q[1] + bit_q;
		vsh = 56'(pv_q >> 16);
		dsum = 56'(dist_q) + 56'(pd_q >> 24);
	end

	always_ff @(posedge clk) begin
		if (load) job_q <= q_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= MODE_IDLE;
			tick_q <= '0;
			slot_q <= '0;
			dist_q <= '0;
			vel_q <= '0;
			used_q <= 1'b0;
			valid_r_q <= 1'b0;
			axis_q <= '0;
			it_q <= '0;
			sqs_q <= '0;
			sqd_q <= '0;
			bit_q <= '0;
			pv_q <= '0;
			pd_q <= '0;
			for (int a = 0; a < 3; a++) begin
				sum_q[a] <= '0;
				prev_q[a] <= '0;
			end
			for (int k = 0; k < 2; k++) begin
				rem_q[k] <= '0;
				root_q[k] <= '0;
			end
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (load) begin
						used_q <= 1'b0;
						if (q_job.is_button) begin
							if (mode_q == MODE_IDLE) begin
								mode_q <= MODE_REC;
								tick_q <= '0;
							end else begin
								mode_q <= MODE_IDLE;
								dist_q <= '0;
								vel_q <= '0;
							end
						end else if (q_job.is_tick && mode_q == MODE_REC) begin
							tick_q <= tick_q + 16'd1;
							if (tick_q + 16'd1 >= rec_ticks) mode_q <= MODE_FIN;
						end
					end
				end
				ST_READ: begin
					valid_r_q <= valid_q[slot_q];
					used_q <= do_sample;
				end
				ST_SUMS: begin
					sum_q[0] <= sum_q[0] + SUM_W'($signed(job_q.rate_x))
						- SUM_W'($signed(old_s1[15:0]));
					sum_q[1] <= sum_q[1] + SUM_W'($signed(job_q.rate_y))
						- SUM_W'($signed(old_s1[31:16]));
					sum_q[2] <= sum_q[2] + SUM_W'($signed(job_q.rate_z))
						- SUM_W'($signed(old_s1[47:32]));
					valid_q[slot_q] <= 1'b1;
					slot_q <= (32'(slot_q) + 1 >= WINDOW_LEN) ? '0 : slot_q + 1'b1;
					axis_q <= '0;
					sqs_q <= '0;
					sqd_q <= '0;
				end
				ST_SQ: begin
					sqs_q <= sqs_q + sq(DIF_W'(sum_q[axis_q]));
					sqd_q <= sqd_q + sq(DIF_W'(sum_q[axis_q]) - DIF_W'(prev_q[axis_q]));
					prev_q[axis_q] <= sum_q[axis_q];
					axis_q <= axis_q + 2'd1;
					if (axis_q == 2'd2) begin
						rem_q[0] <= sqs_q + sq(DIF_W'(sum_q[2]));
						rem_q[1] <= sqd_q + sq(DIF_W'(sum_q[2]) - DIF_W'(prev_q[2]));
						root_q[0] <= '0;
						root_q[1] <= '0;
						bit_q <= SQ_W'(1) << (2 * (ITERS - 1));
						it_q <= '0;
					end
				end
				ST_ROOT: begin
					// One bit-pair per cycle for both roots in lockstep.
					if (rem_q[0] >= t0) begin
						rem_q[0] <= rem_q[0] - t0;
						root_q[0] <= (root_q[0] >> 1) + bit_q;
					end else begin
						root_q[0] <= root_q[0] >> 1;
					end
					if (rem_q[1] >= t1) begin
						rem_q[1] <= rem_q[1] - t1;
						root_q[1] <= (root_q[1] >> 1) + bit_q;
					end else begin
						root_q[1] <= root_q[1] >> 1;
					end
					bit_q <= bit_q >> 2;
					it_q <= it_q + 1'b1;
					if (it_q == ($clog2(ITERS+1))'(ITERS - 1)) begin
						pv_q <= 48'(vel_gain) * 48'(RT_W'(rem_q[0] >= t0 ?
							(root_q[0] >> 1) + bit_q : root_q[0] >> 1));
						pd_q <= 48'(dist_gain) * 48'(RT_W'(rem_q[1] >= t1 ?
							(root_q[1] >> 1) + bit_q : root_q[1] >> 1));
					end
				end
				ST_SCALE: begin
					vel_q <= (vsh > 56'hFFFFFF) ? 24'hFFFFFF : vsh[23:0];
					dist_q <= (dsum > 56'hFFFFFFFF) ? 32'hFFFFFFFF : dsum[31:0];
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/gsdr_ram.sv =====
module gsdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  logic [WIDTH-1:0]                  wdata,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic [WIDTH-1:0]                  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/gyro_speed_distance_recorder_top.sv =====
// Channel | Dir | Payload
// s_axis  | in  | tdata: command[1:0], rate_x[17:2], rate_y[33:18], rate_z[49:34]
// m_axis  | out | tdata: mode[1:0], sample_used[2], velocity[26:3], distance[58:27]
// apb     | in  | 0x0 velocity_gain, 0x4 distance_gain, 0x8 record_ticks
// A sample taken while recording runs through the read, sums, squares, root, scale
// and output states; the two square roots share one bit-pair step per cycle. Other
// commands go straight to output, a sample outside recording through read first.
// A two-beat queue decouples input from the work engine; results wait in place
// until taken. Async reset zeroes control state, idles mode, loads APB defaults.
module gyro_speed_distance_recorder_top #(
	parameter int WINDOW_LEN = gsdr_pkg::WINDOW_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // command, rate_x, rate_y, rate_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // mode, sample_used, velocity, distance
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import gsdr_pkg::*;

	logic [23:0] vel_gain_q, dist_gain_q;
	logic [15:0] rec_ticks_q;
	logic q_valid, q_ready;
	job_t q_job;
	result_t res;
	reg_idx_t idx;

	assign idx = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_gain_q <= VEL_GAIN_RST;
			dist_gain_q <= DIST_GAIN_RST;
			rec_ticks_q <= REC_TICKS_RST;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			unique case (idx)
				REG_VEL_GAIN:  vel_gain_q <= pwdata[23:0];
				REG_DIST_GAIN: dist_gain_q <= pwdata[23:0];
				REG_REC_TICKS: rec_ticks_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_VEL_GAIN:  prdata = {8'd0, vel_gain_q};
			REG_DIST_GAIN: prdata = {8'd0, dist_gain_q};
			REG_REC_TICKS: prdata = {16'd0, rec_ticks_q};
			default:       prdata = '0;
		endcase
	end

	gsdr_front u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
	);

	gsdr_back #(.WINDOW_LEN(WINDOW_LEN)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
		.vel_gain(vel_gain_q), .dist_gain(dist_gain_q), .rec_ticks(rec_ticks_q),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_res(res)
	);

	assign m_tdata = {5'd0, res.distance, res.velocity, res.sample_used, res.mode};

endmodule

// ===== hdl/gsdr_checker.sv =====
module gsdr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("bad mode");
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == 2'd1)
		else $error("sample used outside recording");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == 2'd0 |-> m_tdata[58:3] == 56'd0)
		else $error("idle with nonzero velocity or distance");
endmodule

bind gyro_speed_distance_recorder_top gsdr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
